[rtl/core/amt_pkg.sv]
// Package for the amicable number test block.
// Widths, limits and the control structs shared by the sequencer and the divider.
// No dependencies.
package amt_pkg;

	localparam int NUMBER_WIDTH = 16;
	localparam int CAND_W       = 16;
	localparam int CAND_USE_W   = (NUMBER_WIDTH < CAND_W) ? NUMBER_WIDTH : CAND_W;
	localparam logic [CAND_W-1:0] CAND_MASK = CAND_W'((33'd1 << CAND_USE_W) - 33'd1);

	localparam int PARTNER_W = 18;
	localparam int PSUM_W    = 20;
	localparam int ACC_W     = 22;   // exact divisor sum of an 18-bit number
	localparam int DIV_W     = 10;   // trial divisor, up to sqrt(2^18) + 1
	localparam int SQ_W      = 2 * DIV_W;
	localparam int DIV_CNT_W = $clog2(PARTNER_W);

	localparam logic [PARTNER_W-1:0] PARTNER_MAX = '1;
	localparam logic [PSUM_W-1:0]    PSUM_MAX    = '1;

	typedef struct packed {
		logic                 start;
		logic [PARTNER_W-1:0] dividend;
		logic [DIV_W-1:0]     divisor;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [PARTNER_W-1:0] quotient;
		logic [DIV_W-1:0]     remainder;
	} div_rsp_t;

endpackage

[rtl/core/amt_if.sv]
// Valid/ready channel interfaces for the amicable number test block.
// Depends on amt_pkg for payload widths.
interface amt_req_if;
	logic                       valid;
	logic                       ready;
	logic [amt_pkg::CAND_W-1:0] candidate;

	modport source (output valid, output candidate, input ready);
	modport sink (input valid, input candidate, output ready);
endinterface

interface amt_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          is_amicable;
	logic [amt_pkg::PARTNER_W-1:0] partner;
	logic [amt_pkg::PSUM_W-1:0]    partner_divisor_sum;

	modport source (output valid, output is_amicable, output partner,
		output partner_divisor_sum, input ready);
	modport sink (input valid, input is_amicable, input partner,
		input partner_divisor_sum, output ready);
endinterface

[rtl/core/amt_div.sv]
// Shared restoring divider, one quotient bit per cycle.
// Depends on amt_pkg (div_req_t, div_rsp_t).
module amt_div (
	input  logic              clk,
	input  logic              arst_n,
	input  amt_pkg::div_req_t req,
	output amt_pkg::div_rsp_t rsp
);
	import amt_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [PARTNER_W-1:0] dvd_q;
	logic [DIV_W-1:0]     dvs_q;
	logic [DIV_W-1:0]     rem_q;

	logic [DIV_W:0]   trial;
	logic             qbit;
	logic [DIV_W-1:0] rem_next;

	always_comb begin
		trial    = {rem_q, dvd_q[PARTNER_W-1]};
		qbit     = (trial >= {1'b0, dvs_q});
		rem_next = qbit ? DIV_W'(trial - {1'b0, dvs_q}) : trial[DIV_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(PARTNER_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[PARTNER_W-2:0], qbit};
			rem_q <= rem_next;
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = dvd_q;
	assign rsp.remainder = rem_q;

endmodule

[rtl/core/amicable_number_test_top.sv]
// Top level of the amicable number test: sequencer, accumulator and shared divider.
// Depends on amt_pkg, amt_req_if / amt_rsp_if and amt_div.
//
// channel  dir  payload                                       transfer
// req      in   candidate[15:0]                               valid & ready
// rsp      out  is_amicable, partner[17:0], partner_divisor_sum[19:0]  valid & ready
//
// One candidate at a time; req.ready is high only while idle.
// Each trial divisor d (2 <= d, d*d <= n) takes one division on the shared
// bit-serial divider, first for the candidate and then for its partner.
// Reset returns the sequencer to idle; the result
// holds on rsp until it is taken.
module amicable_number_test_top (
	input logic   clk,
	input logic   arst_n,
	amt_req_if.sink   req,
	amt_rsp_if.source rsp
);
	import amt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_CHECK,
		S_DIV,
		S_DONE
	} state_t;

	state_t               state_q;
	logic                 pass_q;
	logic [CAND_W-1:0]    cand_q;
	logic [PARTNER_W-1:0] n_q;
	logic [DIV_W-1:0]     d_q;
	logic [ACC_W-1:0]     total_q;
	logic [ACC_W-1:0]     partner_q;
	logic                 amic_q;
	logic [PARTNER_W-1:0] partner_out_q;
	logic [PSUM_W-1:0]    psum_out_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic [SQ_W-1:0]  sq;
	logic             n_small;
	logic             trial_ok;
	logic [ACC_W-1:0] pair_add;

	always_comb begin
		sq       = d_q * d_q;
		n_small  = (n_q < PARTNER_W'(2));
		trial_ok = !n_small && (sq <= SQ_W'(n_q));
		if (div_rsp.quotient != PARTNER_W'(d_q))
			pair_add = ACC_W'(d_q) + ACC_W'(div_rsp.quotient);
		else
			pair_add = ACC_W'(d_q);
		div_req.start    = (state_q == S_CHECK) && trial_ok;
		div_req.dividend = n_q;
		div_req.divisor  = d_q;
	end

	amt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			pass_q        <= 1'b0;
			cand_q        <= '0;
			n_q           <= '0;
			d_q           <= '0;
			total_q       <= '0;
			partner_q     <= '0;
			amic_q        <= 1'b0;
			partner_out_q <= '0;
			psum_out_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						cand_q  <= req.candidate & CAND_MASK;
						n_q     <= PARTNER_W'(req.candidate & CAND_MASK);
						pass_q  <= 1'b0;
						state_q <= S_START;
					end
				end
				S_START: begin
					total_q <= n_small ? '0 : ACC_W'(1);
					d_q     <= DIV_W'(2);
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (trial_ok) begin
						state_q <= S_DIV;
					end else if (!pass_q) begin
						partner_q <= total_q;
						n_q       <= total_q[PARTNER_W-1:0];
						pass_q    <= 1'b1;
						state_q   <= S_START;
					end else begin
						amic_q <= (total_q == ACC_W'(cand_q)) &&
							(partner_q != ACC_W'(cand_q));
						partner_out_q <= (partner_q > ACC_W'(PARTNER_MAX)) ?
							PARTNER_MAX : partner_q[PARTNER_W-1:0];
						psum_out_q <= (total_q > ACC_W'(PSUM_MAX)) ?
							PSUM_MAX : total_q[PSUM_W-1:0];
						state_q <= S_DONE;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						if (div_rsp.remainder == '0)
							total_q <= total_q + pair_add;
						d_q     <= d_q + 1'b1;
						state_q <= S_CHECK;
					end
				end
				S_DONE: begin
					if (rsp.ready)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready               = (state_q == S_IDLE);
	assign rsp.valid               = (state_q == S_DONE);
	assign rsp.is_amicable         = amic_q;
	assign rsp.partner             = partner_out_q;
	assign rsp.partner_divisor_sum = psum_out_q;

endmodule
